// ===== hw/rtl/lcr_pkg.sv =====
// Shared types and constants for the load cell reader with tare and scaling.
package lcr_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int AVERAGE_COUNT = 10;

  localparam int READ_W    = 24;
  localparam int SCALE_W   = 16;
  localparam int CFG_W     = 24;
  localparam int CNT_W     = 4;
  localparam int BITCNT_W  = $clog2(SAMPLE_BITS + 1);
  localparam int SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int PROD_W    = READ_W + SCALE_W;
  localparam int DIVIDEND_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DIVISOR_W = READ_W;
  localparam int STEP_W    = $clog2(DIVIDEND_W + 1);

  localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [READ_W-1:0]      READ_MAX  = {READ_W{1'b1}};
  localparam logic [CNT_W-1:0]       AVG_TARGET = CNT_W'(AVERAGE_COUNT);

  typedef enum logic [1:0] {
    REG_AVERAGE_ENABLE = 2'd0,
    REG_FULL_VALUE     = 2'd1,
    REG_RANGE_SCALE    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic dout_level;
    logic tare_request;
  } in_item_t;

  typedef struct packed {
    logic              sck_level;
    logic              result_valid;
    logic [READ_W-1:0] force_res;
    logic [READ_W-1:0] raw_average;
  } out_item_t;

endpackage

// ===== hw/rtl/load_cell_adc_reader_tare_scale_core.sv =====
// Load cell converter reader: serial clock sequencing, averaging, tare and force scaling.
//
// Each input request is one tick (one half period of the converter's serial clock)
// carrying the sampled data pin level and a tare request. Every tick yields exactly
// one result request on the output channel: the serial clock level to drive next,
// a measurement-complete flag, the held scaled force and the finished raw reading.
// A tick that does not finish a measurement is answered in the cycle after acceptance.
// A tick that finishes a measurement runs a bit-serial restoring divider for the
// average, a shift-add multiplier for diff * range_scale and the same divider for
// the span; such a tick is answered once these serial units are done, or after
// the average division when the force is left unchanged.
// Input is taken only while the sequencer is idle and the output register is free
// or being emptied in the same cycle, so a stalled receiver simply holds off the
// next tick and nothing is lost. Configuration writes are taken at any time via
// cfg_write, cfg_index and cfg_data. Synchronous reset restores the register
// defaults (averaging on, full value all ones, range 1000) and puts the reader in
// its wait-for-ready phase with the sums, zero value and held force cleared.
module load_cell_adc_reader_tare_scale_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lcr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lcr_pkg::out_item_t            out_data,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [lcr_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_AVG   = 6'b000010,
    S_FORCE = 6'b000100,
    S_MUL   = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    PH_WAIT  = 4'b0001,
    PH_HIGH  = 4'b0010,
    PH_LOW   = 4'b0100,
    PH_EXTRA = 4'b1000
  } phase_t;

  // Configuration registers
  logic                          average_enable;
  logic [lcr_pkg::READ_W-1:0]    full_value;
  logic [lcr_pkg::SCALE_W-1:0]   range_scale;

  // Tick state
  phase_t                           phase;
  logic [lcr_pkg::BITCNT_W-1:0]     bit_count;
  logic [lcr_pkg::SAMPLE_BITS-1:0]  shift_word;
  logic [lcr_pkg::CNT_W-1:0]        sample_count;
  logic [lcr_pkg::SUM_W-1:0]        sample_sum;
  logic [lcr_pkg::READ_W-1:0]       zero_value;
  logic                             tare_pending;
  logic [lcr_pkg::READ_W-1:0]       force_hold;

  // Arithmetic sequencer
  state_t                            st;
  logic [lcr_pkg::STEP_W-1:0]        step_cnt;
  logic [lcr_pkg::DIVIDEND_W-1:0]    quo;
  logic [lcr_pkg::DIVISOR_W-1:0]     rem;
  logic [lcr_pkg::DIVISOR_W-1:0]     dvsr;
  logic [lcr_pkg::PROD_W:0]          prod;
  logic [lcr_pkg::READ_W-1:0]        diff;
  logic [lcr_pkg::READ_W-1:0]        raw;

  logic                              in_fire;
  logic                              tare_now;
  logic [lcr_pkg::BITCNT_W-1:0]      bit_count_inc;
  logic [lcr_pkg::SAMPLE_BITS-1:0]   word;
  logic [lcr_pkg::SUM_W-1:0]         sum_new;
  logic [lcr_pkg::CNT_W-1:0]         count_new;
  logic [lcr_pkg::CNT_W-1:0]         target;
  logic                              finish;
  logic                              tick_load;
  logic                              tick_sck;

  logic [lcr_pkg::DIVISOR_W:0]       rem_sh;
  logic [lcr_pkg::DIVISOR_W:0]       rem_dif;
  logic                              rem_ge;
  logic [lcr_pkg::DIVISOR_W-1:0]     rem_step;
  logic [lcr_pkg::DIVIDEND_W-1:0]    quo_step;

  logic [lcr_pkg::PROD_W-lcr_pkg::SCALE_W:0] mul_sum;
  logic [lcr_pkg::PROD_W:0]                  mul_full;

  logic [lcr_pkg::READ_W-1:0]        zero_new;

  assign in_ready = (st == S_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign tare_now = tare_pending || in_data.tare_request;

  assign bit_count_inc = bit_count + lcr_pkg::BITCNT_W'(1);
  assign word      = shift_word ^ lcr_pkg::SIGN_FLIP;
  assign sum_new   = sample_sum + lcr_pkg::SUM_W'(word);
  assign count_new = sample_count + lcr_pkg::CNT_W'(1);
  assign target    = average_enable ? lcr_pkg::AVG_TARGET : lcr_pkg::CNT_W'(1);
  assign finish    = (phase == PH_EXTRA) && (count_new >= target);

  always_comb begin
    tick_sck = 1'b0;
    case (phase)
      PH_WAIT:  tick_sck = !in_data.dout_level;
      PH_HIGH:  tick_sck = 1'b0;
      PH_LOW:   tick_sck = 1'b1;
      PH_EXTRA: tick_sck = 1'b0;
      default:  tick_sck = 1'b0;
    endcase
  end

  assign tick_load = in_fire && !finish;

  // One restoring division step, shared by the average and the force division.
  assign rem_sh   = {rem, quo[lcr_pkg::DIVIDEND_W-1]};
  assign rem_dif  = rem_sh - {1'b0, dvsr};
  assign rem_ge   = rem_sh >= {1'b0, dvsr};
  assign rem_step = rem_ge ? rem_dif[lcr_pkg::DIVISOR_W-1:0] : rem_sh[lcr_pkg::DIVISOR_W-1:0];
  assign quo_step = {quo[lcr_pkg::DIVIDEND_W-2:0], rem_ge};

  // One shift-add multiplication step: the multiplier sits in the low bits of prod.
  assign mul_sum  = prod[lcr_pkg::PROD_W:lcr_pkg::SCALE_W]
                  + (prod[0] ? (lcr_pkg::PROD_W-lcr_pkg::SCALE_W+1)'(diff)
                             : (lcr_pkg::PROD_W-lcr_pkg::SCALE_W+1)'(0));
  assign mul_full = {mul_sum, prod[lcr_pkg::SCALE_W-1:0]};

  assign zero_new = tare_pending ? raw : zero_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_enable <= 1'b1;
      full_value     <= lcr_pkg::READ_MAX;
      range_scale    <= lcr_pkg::SCALE_W'(1000);
    end else if (cfg_write) begin
      case (lcr_pkg::reg_index_t'(cfg_index))
        lcr_pkg::REG_AVERAGE_ENABLE: average_enable <= cfg_data[0];
        lcr_pkg::REG_FULL_VALUE:     full_value     <= cfg_data[lcr_pkg::READ_W-1:0];
        lcr_pkg::REG_RANGE_SCALE:    range_scale    <= cfg_data[lcr_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      bit_count    <= '0;
      shift_word   <= '0;
      sample_count <= '0;
      sample_sum   <= '0;
      zero_value   <= '0;
      tare_pending <= 1'b0;
      force_hold   <= '0;
      st           <= S_IDLE;
      step_cnt     <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (in_fire) begin
            tare_pending <= tare_now;
            case (phase)
              PH_WAIT: begin
                if (!in_data.dout_level) begin
                  bit_count  <= '0;
                  shift_word <= '0;
                  phase      <= PH_HIGH;
                end
              end
              PH_HIGH: phase <= PH_LOW;
              PH_LOW: begin
                shift_word <= {shift_word[lcr_pkg::SAMPLE_BITS-2:0], in_data.dout_level};
                bit_count  <= bit_count_inc;
                phase      <= (bit_count_inc >= lcr_pkg::BITCNT_W'(lcr_pkg::SAMPLE_BITS))
                              ? PH_EXTRA : PH_HIGH;
              end
              PH_EXTRA: begin
                phase <= PH_WAIT;
                if (finish) begin
                  sample_sum   <= '0;
                  sample_count <= '0;
                  quo          <= lcr_pkg::DIVIDEND_W'(sum_new);
                  rem          <= '0;
                  dvsr         <= lcr_pkg::DIVISOR_W'(target);
                  step_cnt     <= '0;
                  st           <= S_AVG;
                end else begin
                  sample_sum   <= sum_new;
                  sample_count <= count_new;
                end
              end
              default: phase <= PH_WAIT;
            endcase
          end
        end
        S_AVG: begin
          quo      <= quo_step;
          rem      <= rem_step;
          step_cnt <= step_cnt + lcr_pkg::STEP_W'(1);
          if (step_cnt == lcr_pkg::STEP_W'(lcr_pkg::DIVIDEND_W - 1)) begin
            raw <= quo_step[lcr_pkg::READ_W-1:0];
            st  <= S_FORCE;
          end
        end
        S_FORCE: begin
          zero_value   <= zero_new;
          tare_pending <= 1'b0;
          step_cnt     <= '0;
          diff         <= raw - zero_new;
          dvsr         <= full_value - zero_new;
          prod         <= (lcr_pkg::PROD_W+1)'(range_scale);
          // The force only moves for a positive difference over a positive span.
          st <= ((raw > zero_new) && (full_value > zero_new)) ? S_MUL : S_DONE;
        end
        S_MUL: begin
          prod <= mul_full >> 1;
          if (step_cnt == lcr_pkg::STEP_W'(lcr_pkg::SCALE_W - 1)) begin
            quo      <= lcr_pkg::DIVIDEND_W'(mul_full[lcr_pkg::PROD_W:1]);
            rem      <= '0;
            step_cnt <= '0;
            st       <= S_DIV;
          end else begin
            step_cnt <= step_cnt + lcr_pkg::STEP_W'(1);
          end
        end
        S_DIV: begin
          quo      <= quo_step;
          rem      <= rem_step;
          step_cnt <= step_cnt + lcr_pkg::STEP_W'(1);
          if (step_cnt == lcr_pkg::STEP_W'(lcr_pkg::DIVIDEND_W - 1)) begin
            force_hold <= (|quo_step[lcr_pkg::DIVIDEND_W-1:lcr_pkg::READ_W])
                          ? lcr_pkg::READ_MAX : quo_step[lcr_pkg::READ_W-1:0];
            st <= S_DONE;
          end
        end
        S_DONE: st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  // Output register: ordinary ticks load at acceptance, measurements once finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_load || (st == S_DONE)) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_load) begin
      out_data.sck_level    <= tick_sck;
      out_data.result_valid <= 1'b0;
      out_data.force_res    <= force_hold;
      out_data.raw_average  <= '0;
    end else if (st == S_DONE) begin
      out_data.sck_level    <= 1'b0;
      out_data.result_valid <= 1'b1;
      out_data.force_res    <= force_hold;
      out_data.raw_average  <= raw;
    end
  end

  a_done_loads_result: assert property (@(posedge clk) disable iff (rst)
    (st == S_DONE) |=> (out_valid && out_data.result_valid))
    else $error("finished measurement not presented on the output");

  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    (st == S_DIV) |-> (dvsr != '0))
    else $error("force division started with a zero span");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    sample_count < lcr_pkg::AVG_TARGET || sample_count == '0)
    else $error("sample count passed the averaging target");

  a_result_clock_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_valid) |-> !out_data.sck_level)
    else $error("measurement result with serial clock high");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (in_fire && finish) |=> (st == S_AVG) && !in_ready)
    else $error("input accepted while the arithmetic sequencer runs");

endmodule
